// ===== rtl/wtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_pkg
// shared types and constants for the waypoint turn pruner
// ----------------------------------------------------------------------------
package wtp_pkg;

	localparam int CW = 32;            // coordinate width
	localparam int MW = CW + 1;        // magnitude width of a difference
	localparam int TW = 18;            // turn threshold width
	localparam int DW = 31;            // distance threshold width
	localparam logic [TW-1:0] TURN_RESET = 18'd5374;
	localparam logic [DW-1:0] DIST_RESET = 31'd13107;
	localparam int QW = 17;            // unit component magnitude width

	localparam logic CFG_TURN = 1'b0;
	localparam logic CFG_DIST = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST,
		ST_DIR_A,
		ST_DIR_B,
		ST_TURN,
		ST_EMIT_MID,
		ST_EMIT_LAST
	} state_t;

	// control of the unit direction engine
	typedef struct packed {
		logic start;
	} dir_ctl_t;

	typedef struct packed {
		logic done;
	} dir_sts_t;

endpackage
`default_nettype wire

// ===== rtl/wtp_unit_dir.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_unit_dir
// iterative unit direction of a segment: scale, square sum, root, divide
// ----------------------------------------------------------------------------
module wtp_unit_dir (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wtp_pkg::dir_ctl_t             ctl,
	output wtp_pkg::dir_sts_t                  sts,
	input  wire logic signed [wtp_pkg::CW-1:0] a [3],
	input  wire logic signed [wtp_pkg::CW-1:0] b [3],
	output logic signed [wtp_pkg::QW:0]        u [3]
);
	import wtp_pkg::*;

	typedef enum logic [2:0] {D_IDLE, D_SQ, D_ROOT, D_DIV, D_DONE} dstate_t;

	dstate_t         st_q;
	logic [MW-1:0]   m_q [3];
	logic            neg_q [3];
	logic [61:0]     n2_q;
	logic [63:0]     rem_q;
	logic [63:0]     root_q;
	logic [63:0]     bit_q;
	logic [1:0]      idx_q;
	logic [4:0]      cnt_q;
	logic [32:0]     dr_q;
	logic [QW-1:0]   dq_q;

	logic [MW-1:0]   dm [3];
	logic            dn [3];
	logic [29:0]     ms [3];
	logic [29:0]     msel;
	logic [63:0]     trial;
	logic [32:0]     dsh;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [MW-1:0] d;
			d = {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
			dn[i] = d[MW-1];
			dm[i] = d[MW-1] ? MW'(-d) : MW'(d);
		end
	end

	// shift so that the largest magnitude stays below 2^30
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			priority if (m_q[0] >= (MW'(1) << 32) || m_q[1] >= (MW'(1) << 32)
				|| m_q[2] >= (MW'(1) << 32))
				ms[i] = 30'(m_q[i] >> 3);
			else if (m_q[0] >= (MW'(1) << 31) || m_q[1] >= (MW'(1) << 31)
				|| m_q[2] >= (MW'(1) << 31))
				ms[i] = 30'(m_q[i] >> 2);
			else if (m_q[0] >= (MW'(1) << 30) || m_q[1] >= (MW'(1) << 30)
				|| m_q[2] >= (MW'(1) << 30))
				ms[i] = 30'(m_q[i] >> 1);
			else
				ms[i] = 30'(m_q[i]);
		end
		unique case (idx_q)
			2'd0:    msel = ms[0];
			2'd1:    msel = ms[1];
			default: msel = ms[2];
		endcase
		trial = root_q + bit_q;
		dsh = {dr_q[31:0], 1'b0};
	end

	assign sts.done = (st_q == D_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
		end else begin
			unique case (st_q)
				D_IDLE: if (ctl.start) st_q <= D_SQ;
				D_SQ:   if (idx_q == 2'd2) st_q <= D_ROOT;
				D_ROOT: if (bit_q == 64'd0) st_q <= D_DIV;
				D_DIV:  if (idx_q == 2'd2 && cnt_q == 5'd17) st_q <= D_DONE;
				D_DONE: st_q <= D_IDLE;
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			D_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= dm[i];
					neg_q[i] <= dn[i];
				end
				n2_q <= '0;
				idx_q <= '0;
			end
			D_SQ: begin
				// one square per cycle
				n2_q <= n2_q + 62'(60'(msel) * 60'(msel));
				idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				rem_q <= 64'(n2_q + 62'(60'(msel) * 60'(msel)));
				root_q <= '0;
				bit_q <= 64'd1 << 62;
				cnt_q <= '0;
			end
			D_ROOT: begin
				// partial root runs wide before it settles below 2^31
				if (bit_q != 64'd0) begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				dr_q <= 33'(ms[0]);
				dq_q <= '0;
				cnt_q <= '0;
			end
			D_DIV: begin
				// restoring divide, one quotient bit per cycle
				if (cnt_q == 5'd0) begin
					if (33'(dr_q) >= 33'(root_q)) begin
						dr_q <= dr_q - 33'(root_q);
						dq_q <= 17'd1;
					end else begin
						dq_q <= 17'd0;
					end
					cnt_q <= 5'd1;
				end else if (cnt_q <= 5'd16) begin
					if (dsh >= 33'(root_q)) begin
						dr_q <= dsh - 33'(root_q);
						dq_q <= {dq_q[QW-2:0], 1'b1};
					end else begin
						dr_q <= dsh;
						dq_q <= {dq_q[QW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
				end else begin
					if (root_q == 64'd0)
						u[idx_q] <= '0;
					else
						u[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, dq_q})
							: $signed({1'b0, dq_q});
					cnt_q <= '0;
					dq_q <= '0;
					unique case (idx_q)
						2'd0:    dr_q <= 33'(ms[1]);
						default: dr_q <= 33'(ms[2]);
					endcase
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/waypoint_turn_pruner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_turn_pruner
// streaming 3d waypoint simplifier on distance and turn angle
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: in_x, in_y, in_z; tlast: path_last
// m_axis    out  tdata: out_x, out_y, out_z; tlast: path_end; tuser: run_end
// cfg       in   index 0 turn_threshold, 1 distance_threshold
//
// first and second points of a path skip the distance, direction and turn steps
// an interior point holds the input through a distance sum, two unit direction
// runs, a turn sum and the emit steps, plus result stalls
// a point kept on distance skips both direction runs
// s_axis_tready is low from acceptance until the last result is taken
// reset clears control state and loads the default thresholds
// ----------------------------------------------------------------------------
module waypoint_turn_pruner (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [3*wtp_pkg::CW-1:0]  s_axis_tdata,   // in_x, in_y, in_z
	input  wire logic                      s_axis_tlast,   // path_last
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [3*wtp_pkg::CW-1:0]       m_axis_tdata,   // out_x, out_y, out_z
	output logic                           m_axis_tlast,   // path_end
	output logic                           m_axis_tuser,   // run_end
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic                      cfg_index,
	input  wire logic [31:0]               cfg_data
);
	import wtp_pkg::*;

	state_t st_q, st_d;
	logic [TW-1:0] turn_q;
	logic [DW-1:0] dist_q;
	logic [1:0] seen_q;
	logic signed [CW-1:0] old_q [3], new_q [3], kept_q [3], cur_q [3];
	logic last_q, keep_q;
	logic emit_cur;
	logic [1:0] idx_q;
	logic [99:0] acc_q;
	logic signed [QW:0] u1_q [3];
	logic signed [QW:0] uo [3];
	logic dir_a_q;
	dir_ctl_t dctl;
	dir_sts_t dsts;
	logic signed [CW-1:0] da [3], db [3];
	logic signed [CW:0] dd;
	logic [CW:0] dmag;
	logic signed [QW+1:0] ed;
	logic [QW+1:0] emag;
	logic accept;

	assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			da[i] = dir_a_q ? old_q[i] : new_q[i];
			db[i] = dir_a_q ? new_q[i] : cur_q[i];
		end
		unique case (idx_q)
			2'd0:    begin dd = {new_q[0][CW-1], new_q[0]} - {kept_q[0][CW-1], kept_q[0]};
				ed = {u1_q[0][QW], u1_q[0]} - {uo[0][QW], uo[0]}; end
			2'd1:    begin dd = {new_q[1][CW-1], new_q[1]} - {kept_q[1][CW-1], kept_q[1]};
				ed = {u1_q[1][QW], u1_q[1]} - {uo[1][QW], uo[1]}; end
			default: begin dd = {new_q[2][CW-1], new_q[2]} - {kept_q[2][CW-1], kept_q[2]};
				ed = {u1_q[2][QW], u1_q[2]} - {uo[2][QW], uo[2]}; end
		endcase
		dmag = dd[CW] ? (CW+1)'(-dd) : (CW+1)'(dd);
		emag = ed[QW+1] ? (QW+2)'(-ed) : (QW+2)'(ed);
	end

	wtp_unit_dir u_dir (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .sts(dsts),
		.a(da), .b(db), .u(uo)
	);

	// next state
	always_comb begin
		st_d = st_q;
		dctl.start = 1'b0;
		unique case (st_q)
			ST_IDLE: if (accept) st_d = (seen_q == 2'd2) ? ST_DIST : ST_EMIT_LAST;
			ST_DIST: if (idx_q == 2'd2) st_d = ST_DIR_A;
			ST_DIR_A: begin
				// no direction run when distance already keeps the point
				dctl.start = !dsts.done && !keep_q;
				if (keep_q) st_d = ST_EMIT_MID;
				else if (dsts.done) st_d = ST_DIR_B;
			end
			ST_DIR_B: begin
				dctl.start = !dsts.done;
				if (dsts.done) st_d = ST_TURN;
			end
			ST_TURN: if (idx_q == 2'd2) st_d = ST_EMIT_MID;
			ST_EMIT_MID: if (!m_axis_tvalid) st_d = ST_EMIT_LAST;
			ST_EMIT_LAST: if (!m_axis_tvalid) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			turn_q <= TURN_RESET;
			dist_q <= DIST_RESET;
			seen_q <= '0;
			m_axis_tvalid <= 1'b0;
			keep_q <= 1'b0;
			idx_q <= '0;
			dir_a_q <= 1'b1;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TURN: turn_q <= cfg_data[TW-1:0];
					default:  dist_q <= cfg_data[DW-1:0];
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					keep_q <= 1'b0;
					dir_a_q <= 1'b1;
				end
				ST_DIST: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2)
						keep_q <= (acc_q + 100'(66'(dmag) * 66'(dmag)))
							> 100'(62'(dist_q) * 62'(dist_q));
				end
				ST_DIR_A: if (dsts.done) dir_a_q <= 1'b0;
				ST_TURN: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					if (idx_q == 2'd2)
						keep_q <= (acc_q + 100'(40'(emag) * 40'(emag)))
							> 100'(36'(turn_q) * 36'(turn_q));
				end
				ST_EMIT_MID: if (!m_axis_tvalid && keep_q) m_axis_tvalid <= 1'b1;
				ST_EMIT_LAST: if (!m_axis_tvalid) begin
					if (emit_cur) m_axis_tvalid <= 1'b1;
					if (last_q) seen_q <= 2'd0;
					else if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				acc_q <= '0;
				if (accept) begin
					cur_q[0] <= s_axis_tdata[CW-1:0];
					cur_q[1] <= s_axis_tdata[2*CW-1:CW];
					cur_q[2] <= s_axis_tdata[3*CW-1:2*CW];
					last_q <= s_axis_tlast;
				end
			end
			ST_DIST: acc_q <= (idx_q == 2'd2) ? '0 : acc_q + 100'(66'(dmag) * 66'(dmag));
			ST_DIR_A: if (dsts.done) u1_q <= uo;
			ST_TURN: acc_q <= acc_q + 100'(40'(emag) * 40'(emag));
			ST_EMIT_MID: if (!m_axis_tvalid && keep_q) begin
				m_axis_tdata <= {new_q[2], new_q[1], new_q[0]};
				m_axis_tlast <= 1'b0;
				// the middle point closes the item unless the path ends here
				m_axis_tuser <= !last_q;
				kept_q <= new_q;
			end
			ST_EMIT_LAST: if (!m_axis_tvalid) begin
				m_axis_tdata <= {cur_q[2], cur_q[1], cur_q[0]};
				m_axis_tlast <= last_q;
				m_axis_tuser <= 1'b1;
				if (seen_q == 2'd0) begin
					kept_q <= cur_q;
					new_q <= cur_q;
				end else if (!last_q) begin
					old_q <= new_q;
					new_q <= cur_q;
				end
			end
			default: ;
		endcase
	end

	// last point emitted when first of path or path end
	assign emit_cur = (seen_q == 2'd0) || last_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("path end not last result");
`endif

endmodule
`default_nettype wire
